// File: src/gwch_pkg.sv
// Shared types, sizes and turn-class helper for the gift-wrap hull unit.
package gwch_pkg;

    localparam int MAX_POINTS = 64;
    localparam int IDX_BITS   = 6;
    localparam int CNT_BITS   = 7;
    localparam int COORD_BITS = 16;
    localparam int DIR_BITS   = COORD_BITS + 1;
    localparam int PROD_BITS  = 2 * DIR_BITS;
    localparam int CROSS_BITS = PROD_BITS + 1;

    typedef enum logic [3:0] {
        ST_LOAD,
        ST_MIN_RD,
        ST_MIN_CMP,
        ST_CUR_RD,
        ST_CUR_CAP,
        ST_SCAN_RD,
        ST_DIFF,
        ST_MUL,
        ST_CMP,
        ST_STEP,
        ST_EMIT_RD,
        ST_EMIT
    } state_t;

    // 0: v lies in [0, pi) counterclockwise from u, 1: in [pi, 2pi)
    function automatic logic half_of(
        input logic signed [CROSS_BITS-1:0] cr,
        input logic signed [DIR_BITS-1:0]   ux,
        input logic signed [DIR_BITS-1:0]   uy,
        input logic signed [DIR_BITS-1:0]   vx,
        input logic signed [DIR_BITS-1:0]   vy
    );
        logic res;
        res = 1'b1;
        if (cr != '0)
        begin
            res = cr[CROSS_BITS-1];
        end
        else if (ux != '0 && vx != '0)
        begin
            res = ux[DIR_BITS-1] ^ vx[DIR_BITS-1];
        end
        else if (uy != '0 && vy != '0)
        begin
            res = uy[DIR_BITS-1] ^ vy[DIR_BITS-1];
        end
        return res;
    endfunction

endpackage

// File: src/gift_wrap_convex_hull_unit.sv
// Top level of the gift-wrap (Jarvis march) convex hull unit.
//
// Points enter one item per cycle and are written into a 64-entry point
// memory; a point arriving while 64 are held is dropped and sets the
// overflow flag. The item marked last_point starts the hull: the input
// stalls until every hull item is delivered. The unit first scans the
// memory for the first point with the smallest y (read, then compare),
// then walks the hull. For each vertex it fetches the current point,
// then for every other point reads it and computes the difference, four
// 17x17 products and the compare; it skips the current point itself,
// checks for the end of the scan and then takes the step. Points are
// read one at a time through the single read port of the point memory
// and the candidate compare is serial.
// Vertex indices go to a 64-entry hull buffer, since hull_last and
// degenerate are known only at the end of the walk; each result item
// is then read from the buffer and output, held while out_stall is high.
module gift_wrap_convex_hull_unit
    import gwch_pkg::*;
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic signed [COORD_BITS-1:0] point_x,
    input  logic signed [COORD_BITS-1:0] point_y,
    input  logic                         last_point,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic [IDX_BITS-1:0]          hull_index,
    output logic                         hull_last,
    output logic                         degenerate,
    output logic                         overflow
);

    // point memory: {x, y}
    logic [2*COORD_BITS-1:0] pt_mem [MAX_POINTS];
    logic [2*COORD_BITS-1:0] pt_rdata_reg;
    logic                    pt_we;
    logic [IDX_BITS-1:0]     pt_raddr;

    // hull buffer
    logic [IDX_BITS-1:0]     hull_mem [MAX_POINTS];
    logic [IDX_BITS-1:0]     hull_rdata_reg;
    logic                    hull_we;
    logic [IDX_BITS-1:0]     hull_waddr;
    logic [IDX_BITS-1:0]     hull_wdata;
    logic [IDX_BITS-1:0]     hull_raddr;

    state_t state_reg, state_next;
    logic [CNT_BITS-1:0] cnt_reg, cnt_next;
    logic                ovf_reg, ovf_next;
    logic [CNT_BITS-1:0] j_reg, j_next;    // scan counter
    logic [CNT_BITS-1:0] n_reg, n_next;    // hull vertices found
    logic [CNT_BITS-1:0] k_reg, k_next;    // emit counter
    logic [IDX_BITS-1:0] start_reg, start_next;
    logic [IDX_BITS-1:0] cur_reg, cur_next;
    logic [IDX_BITS-1:0] best_reg, best_next;
    logic                found_reg, found_next;
    logic                hb_reg, hb_next;  // turn class of best

    logic signed [COORD_BITS-1:0] miny_reg, miny_next;
    logic signed [COORD_BITS-1:0] cx_reg, cx_next;
    logic signed [COORD_BITS-1:0] cy_reg, cy_next;
    logic signed [DIR_BITS-1:0]   px_reg, px_next;
    logic signed [DIR_BITS-1:0]   py_reg, py_next;
    logic signed [DIR_BITS-1:0]   bx_reg, bx_next;
    logic signed [DIR_BITS-1:0]   by_reg, by_next;
    logic signed [DIR_BITS-1:0]   dx_reg, dx_next;
    logic signed [DIR_BITS-1:0]   dy_reg, dy_next;
    logic signed [PROD_BITS-1:0]  p1_reg, p1_next;  // px*dy
    logic signed [PROD_BITS-1:0]  p2_reg, p2_next;  // py*dx
    logic signed [PROD_BITS-1:0]  p3_reg, p3_next;  // dx*by
    logic signed [PROD_BITS-1:0]  p4_reg, p4_next;  // dy*bx

    logic signed [COORD_BITS-1:0] rd_x;
    logic signed [COORD_BITS-1:0] rd_y;
    logic signed [CROSS_BITS-1:0] cr_pd;
    logic signed [CROSS_BITS-1:0] cr_db;
    logic                         hc;
    logic                         better;
    logic                         in_acc;

    assign rd_x   = pt_rdata_reg[2*COORD_BITS-1:COORD_BITS];
    assign rd_y   = pt_rdata_reg[COORD_BITS-1:0];
    assign in_acc = in_valid && !in_stall;

    assign cr_pd  = CROSS_BITS'(p1_reg) - CROSS_BITS'(p2_reg);
    assign cr_db  = CROSS_BITS'(p3_reg) - CROSS_BITS'(p4_reg);
    assign hc     = half_of(cr_pd, px_reg, py_reg, dx_reg, dy_reg);
    // strictly smaller turn; ties keep the lower index already held
    assign better = !found_reg ||
                    ((hc != hb_reg) ? (!hc && hb_reg) : (!cr_db[CROSS_BITS-1] && cr_db != '0));

    assign in_stall   = (state_reg != ST_LOAD);
    assign out_valid  = (state_reg == ST_EMIT);
    assign hull_index = hull_rdata_reg;
    assign hull_last  = ((k_reg + CNT_BITS'(1)) == n_reg);
    assign degenerate = (n_reg < CNT_BITS'(3));
    assign overflow   = ovf_reg;

    always_ff @(posedge clk)
    begin
        if (pt_we)
        begin
            pt_mem[cnt_reg[IDX_BITS-1:0]] <= {point_x, point_y};
        end
        pt_rdata_reg <= pt_mem[pt_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (hull_we)
        begin
            hull_mem[hull_waddr] <= hull_wdata;
        end
        hull_rdata_reg <= hull_mem[hull_raddr];
    end

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        ovf_next   = ovf_reg;
        j_next     = j_reg;
        n_next     = n_reg;
        k_next     = k_reg;
        start_next = start_reg;
        cur_next   = cur_reg;
        best_next  = best_reg;
        found_next = found_reg;
        hb_next    = hb_reg;
        miny_next  = miny_reg;
        cx_next    = cx_reg;
        cy_next    = cy_reg;
        px_next    = px_reg;
        py_next    = py_reg;
        bx_next    = bx_reg;
        by_next    = by_reg;
        dx_next    = dx_reg;
        dy_next    = dy_reg;
        p1_next    = p1_reg;
        p2_next    = p2_reg;
        p3_next    = p3_reg;
        p4_next    = p4_reg;
        pt_we      = 1'b0;
        pt_raddr   = j_reg[IDX_BITS-1:0];
        hull_we    = 1'b0;
        hull_waddr = n_reg[IDX_BITS-1:0];
        hull_wdata = best_reg;
        hull_raddr = k_reg[IDX_BITS-1:0];

        unique case (state_reg)
            ST_LOAD:
            begin
                if (in_acc)
                begin
                    if (cnt_reg < CNT_BITS'(MAX_POINTS))
                    begin
                        pt_we    = 1'b1;
                        cnt_next = cnt_reg + CNT_BITS'(1);
                    end
                    else
                    begin
                        ovf_next = 1'b1;
                    end
                    if (last_point)
                    begin
                        j_next     = '0;
                        state_next = ST_MIN_RD;
                    end
                end
            end
            ST_MIN_RD:
            begin
                state_next = ST_MIN_CMP;
            end
            ST_MIN_CMP:
            begin
                if (j_reg == '0 || rd_y < miny_reg)
                begin
                    miny_next  = rd_y;
                    start_next = j_reg[IDX_BITS-1:0];
                end
                j_next = j_reg + CNT_BITS'(1);
                if ((j_reg + CNT_BITS'(1)) == cnt_reg)
                begin
                    // first hull vertex is the start point
                    hull_we    = 1'b1;
                    hull_waddr = '0;
                    hull_wdata = (j_reg == '0 || rd_y < miny_reg) ?
                                 j_reg[IDX_BITS-1:0] : start_reg;
                    cur_next   = hull_wdata;
                    n_next     = CNT_BITS'(1);
                    px_next    = DIR_BITS'(1);
                    py_next    = '0;
                    state_next = (cnt_reg > CNT_BITS'(1)) ? ST_CUR_RD : ST_EMIT_RD;
                    k_next     = '0;
                end
                else
                begin
                    state_next = ST_MIN_RD;
                end
            end
            ST_CUR_RD:
            begin
                pt_raddr   = cur_reg;
                state_next = ST_CUR_CAP;
            end
            ST_CUR_CAP:
            begin
                cx_next    = rd_x;
                cy_next    = rd_y;
                j_next     = '0;
                found_next = 1'b0;
                state_next = ST_SCAN_RD;
            end
            ST_SCAN_RD:
            begin
                if (j_reg == cnt_reg)
                begin
                    state_next = ST_STEP;
                end
                else if (j_reg[IDX_BITS-1:0] == cur_reg)
                begin
                    j_next = j_reg + CNT_BITS'(1);
                end
                else
                begin
                    state_next = ST_DIFF;
                end
            end
            ST_DIFF:
            begin
                dx_next = DIR_BITS'(rd_x) - DIR_BITS'(cx_reg);
                dy_next = DIR_BITS'(rd_y) - DIR_BITS'(cy_reg);
                // coincident point: take direction +x
                if (rd_x == cx_reg && rd_y == cy_reg)
                begin
                    dx_next = DIR_BITS'(1);
                end
                state_next = ST_MUL;
            end
            ST_MUL:
            begin
                p1_next    = PROD_BITS'(px_reg) * PROD_BITS'(dy_reg);
                p2_next    = PROD_BITS'(py_reg) * PROD_BITS'(dx_reg);
                p3_next    = PROD_BITS'(dx_reg) * PROD_BITS'(by_reg);
                p4_next    = PROD_BITS'(dy_reg) * PROD_BITS'(bx_reg);
                state_next = ST_CMP;
            end
            ST_CMP:
            begin
                if (better)
                begin
                    found_next = 1'b1;
                    best_next  = j_reg[IDX_BITS-1:0];
                    bx_next    = dx_reg;
                    by_next    = dy_reg;
                    hb_next    = hc;
                end
                j_next     = j_reg + CNT_BITS'(1);
                state_next = ST_SCAN_RD;
            end
            ST_STEP:
            begin
                k_next = '0;
                if (!found_reg || best_reg == start_reg)
                begin
                    px_next    = bx_reg;
                    py_next    = by_reg;
                    cur_next   = best_reg;
                    state_next = ST_EMIT_RD;
                end
                else
                begin
                    px_next  = bx_reg;
                    py_next  = by_reg;
                    cur_next = best_reg;
                    hull_we  = 1'b1;
                    n_next   = n_reg + CNT_BITS'(1);
                    state_next = ((n_reg + CNT_BITS'(1)) < cnt_reg) ? ST_CUR_RD : ST_EMIT_RD;
                end
            end
            ST_EMIT_RD:
            begin
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (!out_stall)
                begin
                    if ((k_reg + CNT_BITS'(1)) == n_reg)
                    begin
                        cnt_next   = '0;
                        ovf_next   = 1'b0;
                        state_next = ST_LOAD;
                    end
                    else
                    begin
                        k_next     = k_reg + CNT_BITS'(1);
                        state_next = ST_EMIT_RD;
                    end
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_LOAD;
            cnt_reg   <= '0;
            ovf_reg   <= 1'b0;
            j_reg     <= '0;
            n_reg     <= '0;
            k_reg     <= '0;
            found_reg <= 1'b0;
            start_reg <= '0;
            cur_reg   <= '0;
            px_reg    <= DIR_BITS'(1);
            py_reg    <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            ovf_reg   <= ovf_next;
            j_reg     <= j_next;
            n_reg     <= n_next;
            k_reg     <= k_next;
            found_reg <= found_next;
            start_reg <= start_next;
            cur_reg   <= cur_next;
            px_reg    <= px_next;
            py_reg    <= py_next;
        end
    end

    always_ff @(posedge clk)
    begin
        best_reg <= best_next;
        hb_reg   <= hb_next;
        miny_reg <= miny_next;
        cx_reg   <= cx_next;
        cy_reg   <= cy_next;
        bx_reg   <= bx_next;
        by_reg   <= by_next;
        dx_reg   <= dx_next;
        dy_reg   <= dy_next;
        p1_reg   <= p1_next;
        p2_reg   <= p2_next;
        p3_reg   <= p3_next;
        p4_reg   <= p4_next;
    end

endmodule

// File: src/gwch_checker.sv
// Port-level checker for the gift-wrap hull unit, with its bind.
module gwch_checker
    import gwch_pkg::*;
(
    input logic                clk,
    input logic                rst_n,
    input logic                in_valid,
    input logic                in_stall,
    input logic                last_point,
    input logic                out_valid,
    input logic                out_stall,
    input logic [IDX_BITS-1:0] hull_index,
    input logic                hull_last
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(hull_index) && $stable(hull_last))
        else $error("stalled result changed");

    // no new point is taken while results are pending
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> in_stall)
        else $error("input open while emitting");

    // a last point starts the hull computation
    a_last_starts: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && last_point |=> in_stall && !out_valid)
        else $error("last point did not start hull");

endmodule

bind gift_wrap_convex_hull_unit gwch_checker u_gwch_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .last_point (last_point),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .hull_index (hull_index),
    .hull_last  (hull_last)
);
